// ===== rtl/core/rcp_pkg.sv =====
// Package with the constants, codes and types of the command parser.
`timescale 1ns / 1ps
`default_nettype none
package rcp_pkg;

  // Limits of the parser.
  localparam int MAX_ARG_LEN = 1000;
  localparam int MAX_ARGS    = 1000;
  localparam int POS_WIDTH   = 16;

  // Field widths of the channels.
  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int IDX_W   = 10;
  localparam int CODE_W  = 3;
  localparam int EPOS_W  = 16;
  localparam int CNT_W   = 4;

  // Internal widths that follow from the limits.
  localparam int LEN_W   = $clog2(MAX_ARG_LEN + 1);
  localparam int PROD_W  = LEN_W + 4;

  localparam logic [IDX_W-1:0]     ARG_LIMIT =
    IDX_W'((MAX_ARGS < 1023) ? MAX_ARGS : 1023);
  localparam logic [PROD_W-1:0]    LEN_LIMIT = PROD_W'(MAX_ARG_LEN);
  localparam logic [POS_WIDTH-1:0] POS_MAX   = {POS_WIDTH{1'b1}};

  // Framing characters.
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_ARG_BYTE = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_ERROR    = 2'd2,
    KIND_EMPTY    = 2'd3
  } kind_t;

  // Error codes.
  typedef enum logic [CODE_W-1:0] {
    ERR_NO_STAR   = 3'd0,
    ERR_NO_COUNT  = 3'd1,
    ERR_NO_CR     = 3'd2,
    ERR_NO_LF     = 3'd3,
    ERR_NO_DOLLAR = 3'd4,
    ERR_BAD_LEN   = 3'd5,
    ERR_TRUNC     = 3'd6
  } err_code_t;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_STAR    = 4'd0,
    PH_COUNT   = 4'd1,
    PH_CR1     = 4'd2,
    PH_LF1     = 4'd3,
    PH_DOLLAR  = 4'd4,
    PH_LEN     = 4'd5,
    PH_LEN_LF  = 4'd6,
    PH_DATA    = 4'd7,
    PH_DATA_CR = 4'd8,
    PH_DATA_LF = 4'd9
  } phase_t;

endpackage
`default_nettype wire

// ===== rtl/core/rcp_channels.sv =====
// Channel interfaces of the command parser: byte requests in, results out.
`timescale 1ns / 1ps
`default_nettype none
interface rcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface rcp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  arg_byte;
  logic [9:0]  arg_index;
  logic        arg_end;
  logic [2:0]  error_code;
  logic [15:0] error_position;
  logic [3:0]  declared_count;
  logic [9:0]  parsed_count;

  modport source (output valid, output kind, output arg_byte, output arg_index,
                  output arg_end, output error_code, output error_position,
                  output declared_count, output parsed_count, input ready);
  modport sink   (input valid, input kind, input arg_byte, input arg_index,
                  input arg_end, input error_code, input error_position,
                  input declared_count, input parsed_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/resp_command_parser.sv =====
// Command parser top level: framing check and argument byte extraction.
//
//   channel | dir | payload                                  | handshake
//   in_ch   | in  | data_byte, final_byte                    | valid/ready
//   out_ch  | out | kind, arg_byte, arg_index, arg_end,      | valid/ready
//           |     | error_code, error_position, counts       |
//
// One byte request is taken per cycle; its result, if any, appears in the
// output register on the next cycle. The parser state updates in the same
// cycle as the byte is taken, so throughput is one byte per clock.
// Reset returns the parser to the expect-star phase and empties the output.
// A held result stalls input only while the output register stays full.
`timescale 1ns / 1ps
`default_nettype none
module resp_command_parser (
  input  wire logic clk,
  input  wire logic rst_n,
  rcp_in_if.sink    in_ch,
  rcp_out_if.source out_ch
);
  import rcp_pkg::*;

  // Parser state.
  phase_t                 phase_r, phase_nxt;
  logic [POS_WIDTH-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]       decl_r, decl_nxt;
  logic [IDX_W-1:0]       args_r, args_nxt;
  logic [LEN_W-1:0]       accum_r, accum_nxt;
  logic [LEN_W-1:0]       left_r, left_nxt;
  logic                   has_digit_r, has_digit_nxt;
  logic                   fault_r, fault_nxt;

  // Output register.
  logic                   out_valid_r;
  kind_t                  kind_r, kind_nxt;
  logic [BYTE_W-1:0]      abyte_r, abyte_nxt;
  logic [IDX_W-1:0]       aidx_r, aidx_nxt;
  logic                   aend_r, aend_nxt;
  err_code_t              code_r, code_nxt;
  logic [EPOS_W-1:0]      epos_r, epos_nxt;
  logic [CNT_W-1:0]       dcnt_r, dcnt_nxt;
  logic [IDX_W-1:0]       pcnt_r, pcnt_nxt;
  logic                   res_valid;

  logic                   accept;
  logic [BYTE_W-1:0]      b;
  logic                   fin;
  logic                   is_digit;
  logic [3:0]             digit;
  logic [PROD_W-1:0]      len_val;
  logic                   err_now;
  logic [EPOS_W-1:0]      pos16;

  // The input is free whenever the output register can take a result.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign b        = in_ch.data_byte;
  assign fin      = in_ch.final_byte;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign digit    = 4'(b - CH_ZERO);
  assign len_val  = (PROD_W'(accum_r) << 3) + (PROD_W'(accum_r) << 1) + PROD_W'(digit);
  assign pos16    = EPOS_W'(pos_r);

  // Phase transitions and the result of one byte.
  always_comb begin
    phase_nxt     = phase_r;
    decl_nxt      = decl_r;
    args_nxt      = args_r;
    accum_nxt     = accum_r;
    left_nxt      = left_r;
    has_digit_nxt = has_digit_r;
    fault_nxt     = fault_r;
    pos_nxt       = (pos_r != POS_MAX) ? pos_r + 1'b1 : pos_r;
    err_now       = 1'b0;
    res_valid     = 1'b0;
    kind_nxt      = KIND_ARG_BYTE;
    abyte_nxt     = '0;
    aidx_nxt      = '0;
    aend_nxt      = 1'b0;
    code_nxt      = ERR_NO_STAR;
    dcnt_nxt      = '0;
    pcnt_nxt      = '0;

    if (!fault_r) begin
      unique case (phase_r)
        PH_STAR: begin
          if (b == CH_STAR) phase_nxt = PH_COUNT;
          else begin err_now = 1'b1; code_nxt = ERR_NO_STAR; end
        end
        PH_COUNT: begin
          if (is_digit) begin
            decl_nxt  = digit;
            phase_nxt = PH_CR1;
          end else begin
            err_now = 1'b1; code_nxt = ERR_NO_COUNT;
          end
        end
        PH_CR1: begin
          if (b == CH_CR) phase_nxt = PH_LF1;
          else begin err_now = 1'b1; code_nxt = ERR_NO_CR; end
        end
        PH_LF1: begin
          if (b == CH_LF) phase_nxt = PH_DOLLAR;
          else begin err_now = 1'b1; code_nxt = ERR_NO_LF; end
        end
        PH_DOLLAR: begin
          if (b == CH_DOLLAR && args_r < ARG_LIMIT) begin
            accum_nxt     = '0;
            has_digit_nxt = 1'b0;
            phase_nxt     = PH_LEN;
          end else begin
            err_now = 1'b1; code_nxt = ERR_NO_DOLLAR;
          end
        end
        PH_LEN: begin
          if (is_digit) begin
            if (len_val > LEN_LIMIT) begin
              err_now = 1'b1; code_nxt = ERR_BAD_LEN;
            end else begin
              accum_nxt     = LEN_W'(len_val);
              has_digit_nxt = 1'b1;
            end
          end else if (b == CH_CR && has_digit_r) begin
            left_nxt  = accum_r;
            phase_nxt = PH_LEN_LF;
          end else begin
            err_now = 1'b1; code_nxt = ERR_BAD_LEN;
          end
        end
        PH_LEN_LF: begin
          if (b == CH_LF) begin
            if (left_r == '0) begin
              res_valid = 1'b1;
              kind_nxt  = KIND_EMPTY;
              aidx_nxt  = args_r;
              phase_nxt = PH_DATA_CR;
            end else begin
              phase_nxt = PH_DATA;
            end
          end else begin
            err_now = 1'b1; code_nxt = ERR_NO_LF;
          end
        end
        PH_DATA: begin
          res_valid = 1'b1;
          kind_nxt  = KIND_ARG_BYTE;
          abyte_nxt = b;
          aidx_nxt  = args_r;
          aend_nxt  = (left_r == LEN_W'(1));
          if (left_r != '0) left_nxt = left_r - 1'b1;
          if (left_r <= LEN_W'(1)) phase_nxt = PH_DATA_CR;
        end
        PH_DATA_CR: begin
          if (b == CH_CR) phase_nxt = PH_DATA_LF;
          else begin err_now = 1'b1; code_nxt = ERR_NO_CR; end
        end
        PH_DATA_LF: begin
          if (b == CH_LF) begin
            args_nxt  = args_r + 1'b1;
            phase_nxt = PH_DOLLAR;
          end else begin
            err_now = 1'b1; code_nxt = ERR_NO_LF;
          end
        end
        default: phase_nxt = PH_STAR;
      endcase
    end

    // A framing fault replaces any other result of this byte.
    if (err_now) begin
      res_valid = 1'b1;
      kind_nxt  = KIND_ERROR;
      abyte_nxt = '0;
      aidx_nxt  = '0;
      aend_nxt  = 1'b0;
      fault_nxt = 1'b1;
    end

    // The final byte closes the command and clears all parser state.
    if (fin) begin
      if (!err_now && !fault_r) begin
        res_valid = 1'b1;
        abyte_nxt = '0;
        aidx_nxt  = '0;
        aend_nxt  = 1'b0;
        if (phase_nxt == PH_DOLLAR) begin
          kind_nxt = KIND_DONE;
          dcnt_nxt = decl_nxt;
          pcnt_nxt = args_nxt;
        end else begin
          kind_nxt = KIND_ERROR;
          code_nxt = ERR_TRUNC;
        end
      end
      phase_nxt     = PH_STAR;
      pos_nxt       = '0;
      decl_nxt      = '0;
      args_nxt      = '0;
      accum_nxt     = '0;
      left_nxt      = '0;
      has_digit_nxt = 1'b0;
      fault_nxt     = 1'b0;
    end

    epos_nxt = (kind_nxt == KIND_ERROR) ? pos16 : '0;
    if (kind_nxt != KIND_ERROR) code_nxt = ERR_NO_STAR;
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_STAR;
      pos_r       <= '0;
      decl_r      <= '0;
      args_r      <= '0;
      accum_r     <= '0;
      left_r      <= '0;
      has_digit_r <= 1'b0;
      fault_r     <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      decl_r      <= decl_nxt;
      args_r      <= args_nxt;
      accum_r     <= accum_nxt;
      left_r      <= left_nxt;
      has_digit_r <= has_digit_nxt;
      fault_r     <= fault_nxt;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      kind_r  <= kind_nxt;
      abyte_r <= abyte_nxt;
      aidx_r  <= aidx_nxt;
      aend_r  <= aend_nxt;
      code_r  <= code_nxt;
      epos_r  <= epos_nxt;
      dcnt_r  <= dcnt_nxt;
      pcnt_r  <= pcnt_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = kind_r;
  assign out_ch.arg_byte       = abyte_r;
  assign out_ch.arg_index      = aidx_r;
  assign out_ch.arg_end        = aend_r;
  assign out_ch.error_code     = code_r;
  assign out_ch.error_position = epos_r;
  assign out_ch.declared_count = dcnt_r;
  assign out_ch.parsed_count   = pcnt_r;

endmodule
`default_nettype wire

// ===== tb/resp_command_parser_tb.sv =====
// Testbench for the command parser: framing checks, argument bytes and counts.
`timescale 1ns / 1ps
module resp_command_parser_tb;
  import rcp_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // One parser result as it appears on the output channel.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  arg_byte;
    logic [9:0]  arg_index;
    logic        arg_end;
    err_code_t   error_code;
    logic [15:0] error_position;
    logic [3:0]  declared_count;
    logic [9:0]  parsed_count;
  } parse_result_t;

  localparam string CR   = "\015";
  localparam string LF   = "\012";
  localparam string CRLF = "\015\012";

  logic clk;
  logic rst_n;

  rcp_in_if  in_ch ();
  rcp_out_if out_ch ();

  resp_command_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Expected results in the order the parser must produce them.
  parse_result_t expected_results[$];

  // Shadow copy of the parser state.
  phase_t               parser_phase;
  logic [POS_WIDTH-1:0] byte_pos;
  logic [3:0]           declared_args;
  logic [9:0]           args_parsed;
  int unsigned          length_accum;
  logic [9:0]           data_left;
  logic                 length_seen;
  logic                 fault_seen;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_left;
  int mismatch_count;

  // Free-running clock, 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic parse_result_t blank_result(kind_t k);
    parse_result_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  function automatic parse_result_t fault_result(err_code_t code, logic [15:0] at);
    parse_result_t r;
    r = blank_result(KIND_ERROR);
    r.error_code = code;
    r.error_position = at;
    return r;
  endfunction

  task automatic clear_parser();
    parser_phase  = PH_STAR;
    byte_pos      = '0;
    declared_args = '0;
    args_parsed   = '0;
    length_accum  = 0;
    data_left     = '0;
    length_seen   = 1'b0;
    fault_seen    = 1'b0;
  endtask

  // Advance the shadow parser by one accepted byte and queue its result, if any.
  task automatic parse_byte(input logic [7:0] b, input logic fin);
    parse_result_t r;
    logic          have;
    logic          err_now;
    logic          is_digit;
    logic [15:0]   at;
    int unsigned   v;
    r        = '0;
    have     = 1'b0;
    err_now  = 1'b0;
    at       = 16'(byte_pos);
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    if (!fault_seen) begin
      case (parser_phase)
        PH_STAR: begin
          if (b == CH_STAR) parser_phase = PH_COUNT;
          else begin r = fault_result(ERR_NO_STAR, at); err_now = 1'b1; end
        end
        PH_COUNT: begin
          if (is_digit) begin
            declared_args = 4'(b - CH_ZERO);
            parser_phase  = PH_CR1;
          end else begin r = fault_result(ERR_NO_COUNT, at); err_now = 1'b1; end
        end
        PH_CR1: begin
          if (b == CH_CR) parser_phase = PH_LF1;
          else begin r = fault_result(ERR_NO_CR, at); err_now = 1'b1; end
        end
        PH_LF1: begin
          if (b == CH_LF) parser_phase = PH_DOLLAR;
          else begin r = fault_result(ERR_NO_LF, at); err_now = 1'b1; end
        end
        PH_DOLLAR: begin
          if (b == CH_DOLLAR && args_parsed < ARG_LIMIT) begin
            length_accum = 0;
            length_seen  = 1'b0;
            parser_phase = PH_LEN;
          end else begin r = fault_result(ERR_NO_DOLLAR, at); err_now = 1'b1; end
        end
        PH_LEN: begin
          if (is_digit) begin
            v = length_accum * 10 + int'(b - CH_ZERO);
            if (v > MAX_ARG_LEN) begin
              r = fault_result(ERR_BAD_LEN, at);
              err_now = 1'b1;
            end else begin
              length_accum = v;
              length_seen  = 1'b1;
            end
          end else if (b == CH_CR && length_seen) begin
            data_left    = 10'(length_accum);
            parser_phase = PH_LEN_LF;
          end else begin r = fault_result(ERR_BAD_LEN, at); err_now = 1'b1; end
        end
        PH_LEN_LF: begin
          if (b == CH_LF) begin
            if (data_left == 0) begin
              // A zero-length argument is reported as one empty mark.
              r = blank_result(KIND_EMPTY);
              r.arg_index = args_parsed;
              have = 1'b1;
              parser_phase = PH_DATA_CR;
            end else parser_phase = PH_DATA;
          end else begin r = fault_result(ERR_NO_LF, at); err_now = 1'b1; end
        end
        PH_DATA: begin
          r = blank_result(KIND_ARG_BYTE);
          r.arg_byte  = b;
          r.arg_index = args_parsed;
          r.arg_end   = (data_left == 1);
          have = 1'b1;
          if (data_left > 0) data_left--;
          if (data_left == 0) parser_phase = PH_DATA_CR;
        end
        PH_DATA_CR: begin
          if (b == CH_CR) parser_phase = PH_DATA_LF;
          else begin r = fault_result(ERR_NO_CR, at); err_now = 1'b1; end
        end
        PH_DATA_LF: begin
          if (b == CH_LF) begin
            args_parsed++;
            parser_phase = PH_DOLLAR;
          end else begin r = fault_result(ERR_NO_LF, at); err_now = 1'b1; end
        end
        default: parser_phase = PH_STAR;
      endcase
      if (err_now) begin
        fault_seen = 1'b1;
        have = 1'b1;
      end
    end

    if (byte_pos != POS_MAX) byte_pos++;

    // The final byte closes the command: done between arguments, else truncated.
    if (fin) begin
      if (!fault_seen) begin
        if (parser_phase == PH_DOLLAR) begin
          r = blank_result(KIND_DONE);
          r.declared_count = declared_args;
          r.parsed_count   = args_parsed;
        end else begin
          r = fault_result(ERR_TRUNC, at);
        end
        have = 1'b1;
      end
      clear_parser();
    end

    if (have) expected_results.push_back(r);
  endtask

  // Receiver side: long hold-off when asked, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_ch.ready = 1'b0;
      hold_off_left--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    parse_result_t seen;
    parse_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.kind           = kind_t'(out_ch.kind);
      seen.arg_byte       = out_ch.arg_byte;
      seen.arg_index      = out_ch.arg_index;
      seen.arg_end        = out_ch.arg_end;
      seen.error_code     = err_code_t'(out_ch.error_code);
      seen.error_position = out_ch.error_position;
      seen.declared_count = out_ch.declared_count;
      seen.parsed_count   = out_ch.parsed_count;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result kind=%0d byte=%h idx=%0d end=%b code=%0d pos=%0d",
                   $realtime, seen.kind, seen.arg_byte, seen.arg_index, seen.arg_end,
                   seen.error_code, seen.error_position);
      end else begin
        want = expected_results.pop_front();
        if (seen !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected kind=%0d byte=%h idx=%0d end=%b code=%0d pos=%0d decl=%0d parsed=%0d",
                     want.kind, want.arg_byte, want.arg_index, want.arg_end,
                     want.error_code, want.error_position, want.declared_count,
                     want.parsed_count);
            $display("  actual   kind=%0d byte=%h idx=%0d end=%b code=%0d pos=%0d decl=%0d parsed=%0d",
                     seen.kind, seen.arg_byte, seen.arg_index, seen.arg_end,
                     seen.error_code, seen.error_position, seen.declared_count,
                     seen.parsed_count);
          end
        end
      end
    end
  end

  // Offer one byte request; called and returning at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.data_byte  = b;
    in_ch.final_byte = fin;
    do @(posedge clk); while (!in_ch.ready);
    parse_byte(b, fin);
    @(negedge clk);
  endtask

  task automatic send_command(input byte_q_t cmd);
    foreach (cmd[i]) send_byte(cmd[i], i == cmd.size() - 1);
  endtask

  function automatic byte_q_t text_bytes(string s);
    byte_q_t q;
    foreach (s[i]) q.push_back(s[i]);
    return q;
  endfunction

  task automatic send_text(string s);
    send_command(text_bytes(s));
  endtask

  // One argument: dollar, decimal length, CRLF, random data and CRLF.
  function automatic byte_q_t arg_frame(int unsigned len, bit zero_pad);
    byte_q_t q;
    q.push_back(CH_DOLLAR);
    if (zero_pad) q.push_back(CH_ZERO);
    q = {q, text_bytes($sformatf("%0d", len))};
    q.push_back(CH_CR);
    q.push_back(CH_LF);
    repeat (len) q.push_back(8'($urandom));
    q.push_back(CH_CR);
    q.push_back(CH_LF);
    return q;
  endfunction

  function automatic byte_q_t command_head(logic [3:0] count);
    byte_q_t q;
    q = {CH_STAR, CH_ZERO + 8'(count), CH_CR, CH_LF};
    return q;
  endfunction

  // Mostly well-formed commands with random content, some broken, some noise.
  function automatic byte_q_t random_command();
    byte_q_t     cmd;
    int unsigned roll;
    int unsigned len;
    int unsigned idx;
    logic [7:0]  near_bytes[5];
    near_bytes = '{CH_CR, CH_LF, CH_DOLLAR, CH_STAR, CH_NINE};
    roll = $urandom_range(99);
    if (roll < 8) begin
      repeat ($urandom_range(12, 1)) cmd.push_back(8'($urandom));
      if ($urandom_range(1)) cmd[0] = CH_STAR;
      return cmd;
    end
    cmd = command_head(4'($urandom_range(9)));
    for (int i = 0; i < $urandom_range(4); i++) begin
      if ($urandom_range(49) == 0) begin
        // Length beyond the limit; nothing sensible can follow it.
        cmd.push_back(CH_DOLLAR);
        cmd = {cmd, text_bytes($sformatf("%0d", $urandom_range(9999, MAX_ARG_LEN + 1)))};
        break;
      end
      roll = $urandom_range(99);
      if (roll < 20)      len = 0;
      else if (roll < 85) len = $urandom_range(6, 1);
      else if (roll < 97) len = $urandom_range(40, 7);
      else                len = $urandom_range(300, 100);
      cmd = {cmd, arg_frame(len, $urandom_range(9) == 0)};
    end
    if ($urandom_range(3) == 0) begin
      idx = $urandom_range(cmd.size() - 1);
      case ($urandom_range(2))
        0: cmd[idx] = 8'($urandom);
        1: cmd = cmd[0:idx];
        default: cmd[idx] = near_bytes[$urandom_range(4)];
      endcase
    end
    return cmd;
  endfunction

  // Stop offering requests and let every queued result drain.
  task automatic wait_for_results();
    in_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Short commands that hit every result kind and every framing fault.
  task automatic test_directed_frames();
    byte_q_t cmd;
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    send_text({"*2", CRLF, "$3", CRLF, "abc", CRLF, "$0", CRLF, CRLF});
    cmd = {command_head(4'd1), text_bytes({"$2", CRLF})};
    cmd = {cmd, 8'h00, 8'hFF, CH_CR, CH_LF};
    send_command(cmd);
    send_text({"*0", CRLF});
    send_text("?");
    send_text("*");
    send_text("*x12");
    send_text({"*3", "x"});
    send_text({"*3", CR, "$"});
    send_text({"*1", CRLF, "X"});
    send_text({"*1", CRLF, "$", CRLF});
    send_text({"*1", CRLF, "$1a"});
    send_text({"*1", CRLF, "$1001", CRLF});
    send_text({"*1", CRLF, "$0007", CRLF, "1234567", CRLF});
    send_text({"*1", CRLF, "$1", CR, "x"});
    send_text({"*1", CRLF, "$2", CRLF, "ab"});
    send_text({"*1", CRLF, "$1", CRLF, "ab"});
    send_text({"*1", CRLF, "$1", CRLF, "a", CR, "b"});
    send_text({"*1", CRLF, "$0", CRLF});
    send_text({"*1", CRLF, "$9"});
    wait_for_results();
  endtask

  // The receiver holds off for a long time while the sender keeps offering bytes.
  task automatic test_output_backpressure();
    byte_q_t cmd;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 300;
    cmd = {command_head(4'd2), arg_frame(50, 1'b0), arg_frame(50, 1'b0)};
    send_command(cmd);
    wait_for_results();
  endtask

  task automatic run_traffic_phase(int items, int idle_pct, int stall_pct);
    byte_q_t cmd;
    int      sent;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      cmd = random_command();
      send_command(cmd);
      sent += cmd.size();
    end
  endtask

  // Random commands under each mix of sender gaps and receiver stalls.
  task automatic test_random_traffic();
    run_traffic_phase(280, 0, 0);
    run_traffic_phase(280, 60, 0);
    run_traffic_phase(280, 0, 60);
    run_traffic_phase(280, 6, 6);
    in_ch.valid = 1'b0;
    wait_for_results();
  endtask

  // Main sequence.
  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.final_byte = 1'b0;
    out_ch.ready     = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_off_left    = 0;
    mismatch_count   = 0;
    clear_parser();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_frames();
    test_output_backpressure();
    test_random_traffic();

    in_ch.valid = 1'b0;
    wait_for_results();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
